FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the knapsack block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/kdp_pkg.sv
// ----------------------------------------------------------------------------
// kdp_pkg
// Types and fixed constants for the 0/1 knapsack dynamic programming block.
// ----------------------------------------------------------------------------
package kdp_pkg;

    // Fixed field widths.
    localparam int CAP_W    = 10;
    localparam int WEIGHT_W = 10;
    localparam int VALUE_W  = 32;
    localparam int OUT_W    = 48;

    // Largest value that the result port can show.
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } kdp_state_t;

endpackage

FILE: rtl/kdp_table.sv
// ----------------------------------------------------------------------------
// kdp_table
// Value table memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module kdp_table #(
    parameter int DEPTH = 1024,
    parameter int EW    = 48,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [EW-1:0] rd_data_a,
    output logic [EW-1:0] rd_data_b,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);

    logic [EW-1:0] table_mem [DEPTH];
    logic [EW-1:0] rd_data_a_reg;
    logic [EW-1:0] rd_data_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        rd_data_a_reg <= table_mem[rd_addr_a];
        rd_data_b_reg <= table_mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: rtl/kdp_alu.sv
// ----------------------------------------------------------------------------
// kdp_alu
// Shared update unit: saturating add of the item value and max with old entry.
// ----------------------------------------------------------------------------
module kdp_alu #(
    parameter int EW = 48
) (
    input  logic [EW-1:0]               old_entry,
    input  logic [EW-1:0]               src_entry,
    input  logic [kdp_pkg::VALUE_W-1:0] item_val,
    input  logic                        hit,
    output logic [EW-1:0]               new_entry,
    output logic                        sat_hit
);
    import kdp_pkg::*;

    localparam int SW = ((EW > VALUE_W) ? EW : VALUE_W) + 1;
    localparam logic [EW-1:0] EMAX = {EW{1'b1}};

    logic [SW-1:0] sum_wide;
    logic          sum_ovf;
    logic [EW-1:0] sum_sat;

    // Sum with one spare bit, then clamp to the entry range.
    always_comb
    begin
        sum_wide = SW'(src_entry) + SW'(item_val);
        sum_ovf  = sum_wide > SW'(EMAX);
        sum_sat  = sum_ovf ? EMAX : EW'(sum_wide);
    end

    // The entry keeps its old value when the item does not fit.
    assign new_entry = (hit && (sum_sat > old_entry)) ? sum_sat : old_entry;
    assign sat_hit   = hit && sum_ovf;

endmodule

FILE: rtl/kdp_seq.sv
// ----------------------------------------------------------------------------
// kdp_seq
// Sequencer: clearing passes, descending table sweep and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kdp_seq #(
    parameter int DEPTH = 1024,
    parameter int EW    = 48,
    parameter int AW    = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         new_set,
    input  logic [kdp_pkg::WEIGHT_W-1:0] item_weight,
    input  logic [kdp_pkg::VALUE_W-1:0]  item_value,
    input  logic [kdp_pkg::CAP_W-1:0]    capacity,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kdp_pkg::OUT_W-1:0]    best_value,
    output logic                         saturated,
    output logic [AW-1:0]                rd_addr_a,
    output logic [AW-1:0]                rd_addr_b,
    input  logic [EW-1:0]                rd_data_a,
    input  logic [EW-1:0]                rd_data_b,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [EW-1:0]                wr_data
);
    import kdp_pkg::*;

    localparam int CW = (AW > CAP_W) ? AW : CAP_W;
    localparam int BW = (EW > OUT_W) ? EW : OUT_W;
    localparam logic [CW-1:0] DEPTH_M1 = CW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    kdp_state_t            state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         c_reg, c_next;
    logic [AW-1:0]         cap_reg, cap_next;
    logic [WEIGHT_W-1:0]   w_reg, w_next;
    logic [VALUE_W-1:0]    val_reg, val_next;
    logic                  p1_valid_reg, p1_valid_next;
    logic [AW-1:0]         p1_addr_reg, p1_addr_next;
    logic                  p1_hit_reg, p1_hit_next;
    logic                  ovf_reg, ovf_next;
    logic [OUT_W-1:0]      best_reg, best_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_best_reg, out_best_next;
    logic                  out_sat_reg, out_sat_next;

    logic [CW-1:0]         cap_ext;
    logic [AW-1:0]         cap_in;
    logic                  hit_now;
    logic [AW-1:0]         src_addr;
    logic                  clearing;
    logic [EW-1:0]         alu_new;
    logic                  alu_ovf;
    logic [BW-1:0]         best_wide;
    logic [OUT_W-1:0]      best_clamped;

    // Capacity limited to the last table entry.
    assign cap_ext = CW'(capacity);
    assign cap_in  = (cap_ext > DEPTH_M1) ? LAST_ADDR : AW'(cap_ext);

    // Fit test and source address for the entry being issued.
    assign hit_now  = CW'(w_reg) <= CW'(c_reg);
    assign src_addr = AW'(CW'(c_reg) - CW'(w_reg));

    // Shared update unit works on the registered read data.
    kdp_alu #(
        .EW (EW)
    ) u_alu (
        .old_entry (rd_data_a),
        .src_entry (rd_data_b),
        .item_val  (val_reg),
        .hit       (p1_hit_reg),
        .new_entry (alu_new),
        .sat_hit   (alu_ovf)
    );

    // Clamp the answer to the result width.
    assign best_wide    = BW'(alu_new);
    assign best_clamped = (best_wide > BW'(OUT_MAX)) ? OUT_MAX : OUT_W'(best_wide);

    // Memory port control.
    assign clearing  = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign rd_addr_a = c_reg;
    assign rd_addr_b = src_addr;
    assign wr_en     = clearing || p1_valid_reg;
    assign wr_addr   = clearing ? clr_reg : p1_addr_reg;
    assign wr_data   = clearing ? '0 : alu_new;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign best_value = out_best_reg;
    assign saturated  = out_sat_reg;

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            p1_valid_reg  <= p1_valid_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        cap_reg      <= cap_next;
        w_reg        <= w_next;
        val_reg      <= val_next;
        p1_addr_reg  <= p1_addr_next;
        p1_hit_reg   <= p1_hit_next;
        best_reg     <= best_next;
        out_best_reg <= out_best_next;
        out_sat_reg  <= out_sat_next;
    end

    // Next state and sweep control.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        c_next         = c_reg;
        cap_next       = cap_reg;
        w_next         = w_reg;
        val_next       = val_reg;
        p1_valid_next  = 1'b0;
        p1_addr_next   = p1_addr_reg;
        p1_hit_next    = p1_hit_reg;
        ovf_next       = ovf_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        out_best_next  = out_best_reg;
        out_sat_next   = out_sat_reg;

        // A waiting result leaves when the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Second step of each update: write back and collect the answer.
        if (p1_valid_reg)
        begin
            if (alu_ovf)
            begin
                ovf_next = 1'b1;
            end
            if (p1_addr_reg == cap_reg)
            begin
                best_next = best_clamped;
            end
        end

        unique case (state_reg)
            ST_INIT:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cap_next  = cap_in;
                    c_next    = cap_in;
                    w_next    = item_weight;
                    val_next  = item_value;
                    best_next = '0;
                    if (new_set)
                    begin
                        ovf_next   = 1'b0;
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (cap_in == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = (cap_reg == '0) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                p1_valid_next = 1'b1;
                p1_addr_next  = c_reg;
                p1_hit_next   = hit_now;
                c_next        = c_reg - 1'b1;
                if (c_reg == AW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = best_reg;
                    out_sat_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Entry zero is only ever written by a clearing pass.
    `ASSERT_IMPLIES(a_entry_zero_kept, clk, rst_n, wr_en && (wr_addr == '0), clearing)
    // Sweep writes stay within one to the latched capacity.
    `ASSERT_IMPLIES(a_sweep_range, clk, rst_n, p1_valid_reg, (p1_addr_reg != '0) && (p1_addr_reg <= cap_reg))
    // The saturation flag only rises after a fitting update that overflowed.
    `ASSERT_IMPLIES(a_ovf_source, clk, rst_n, $rose(ovf_reg), $past(p1_valid_reg && p1_hit_reg))
    // A finished item always reaches the output register once the slot is free.
    `ASSERT_NEXT(a_done_loads, clk, rst_n, (state_reg == ST_DONE) && (!out_valid_reg || !out_stall), out_valid_reg && (state_reg == ST_IDLE))

endmodule

FILE: rtl/zero_one_knapsack_dp_top.sv
// Streaming 0/1 knapsack solver by dynamic programming over a one-row table.
// Input channel (in_valid / in_stall) carries one item: new_set, item_weight,
// item_value. Output channel (out_valid / out_stall) returns one item per
// input: best_value at the configured capacity and the saturated flag.
// capacity is to be written through cfg_wr_en / cfg_wr_data while the block
// idles; the block itself does not enforce this. Each item sweeps table
// entries from capacity down to 1, one read-modify-write per cycle through
// a shared update unit on a dual-read memory; an item at capacity zero skips
// the sweep. An item with new_set first runs a clearing pass over all
// TABLE_DEPTH entries. in_stall is high from accept until the result is in
// the output register.
// After reset the block runs a clearing pass over all TABLE_DEPTH entries
// with in_stall high; configuration writes are taken during it. If the
// receiver stalls, the result waits in the output register; a further
// finished item waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
// zero_one_knapsack_dp_top
// Top level: configuration register, value table and sweep sequencer.
// ----------------------------------------------------------------------------
module zero_one_knapsack_dp_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [kdp_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         new_set,
    input  logic [kdp_pkg::WEIGHT_W-1:0] item_weight,
    input  logic [kdp_pkg::VALUE_W-1:0]  item_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kdp_pkg::OUT_W-1:0]    best_value,
    output logic                         saturated
);
    import kdp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [CAP_W-1:0]       capacity_reg;
    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic [ENTRY_WIDTH-1:0] rd_data_a;
    logic [ENTRY_WIDTH-1:0] rd_data_b;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Best-value table.
    kdp_table #(
        .DEPTH (TABLE_DEPTH),
        .EW    (ENTRY_WIDTH),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Sweep sequencer with the shared update unit.
    kdp_seq #(
        .DEPTH (TABLE_DEPTH),
        .EW    (ENTRY_WIDTH),
        .AW    (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .new_set     (new_set),
        .item_weight (item_weight),
        .item_value  (item_value),
        .capacity    (capacity_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_value  (best_value),
        .saturated   (saturated),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

endmodule
